// ----- rtl/core/md5sh_pkg.sv -----
package md5sh_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_RUN,
    S_FOLD,
    S_OUT
  } state_t;

  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] SHIFT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [6:0] RUN_END    = 7'd65;
  localparam logic [1:0] LAST_INDEX = 2'd3;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] x;
    logic [3:0] res;
    x = r[3:0];
    case (r[5:4])
      2'd0:    res = x;
      2'd1:    res = 4'((x << 2) + x + 4'd1);
      2'd2:    res = 4'((x << 1) + x + 4'd5);
      default: res = 4'((x << 3) - x);
    endcase
    return res;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    case (phase)
      2'd0:    res = d ^ (b & (c ^ d));
      2'd1:    res = c ^ (d & (b ^ c));
      2'd2:    res = b ^ c ^ d;
      default: res = c ^ (b | ~d);
    endcase
    return res;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] w;
    w = {v, v} << s;
    return w[63:32];
  endfunction

endpackage

// ----- rtl/core/md5_stream_hasher_core.sv -----
// channel | direction | payload                            | handshake
// in      | sink      | data_byte, byte_valid, is_last     | in_valid / in_stall
// out     | source    | digest_word, word_index, last_word | out_valid / out_stall
//
// A byte beat is merged into the current word; the beat that fills a 64-byte block
// starts the 64 rounds, one per cycle out of the 16-word block memory, then the fold.
// A last beat adds 16 - pos/4 padding writes and the rounds, a second padded block
// (16 writes plus rounds) if 56 or more bytes are pending, then four output beats.
// Reset loads the initial chaining words and clears the count; the block memory is
// not cleared. in_stall is high whenever a block or digest is in progress.
module md5_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  import md5sh_pkg::*;

  state_t       state;
  state_t       state_next;
  logic [60:0]  count;
  logic [60:0]  count_next;
  logic [31:0]  chain [4];
  logic [31:0]  acc;
  logic [31:0]  acc_merged;
  logic [31:0]  head_word;
  logic [31:0]  pad_word;
  logic [63:0]  bit_len;
  logic [5:0]   pos;
  logic         in_fire;
  logic         pass2;
  logic         pad_due;
  logic         final_blk;
  logic         len_blk;
  logic [3:0]   pad_w;
  logic [6:0]   rc;
  logic [5:0]   r1;
  logic [5:0]   r2;
  logic [1:0]   out_idx;
  logic [31:0]  a;
  logic [31:0]  b;
  logic [31:0]  c;
  logic [31:0]  d;
  logic [31:0]  mk;
  logic [31:0]  t_sum;
  logic [31:0]  b_next;
  logic [31:0]  blk_mem [16];
  logic [31:0]  rdata;
  logic         mem_we;
  logic [3:0]   mem_waddr;
  logic [31:0]  mem_wdata;
  logic [3:0]   mem_raddr;

  assign pos        = count[5:0];
  assign in_fire    = in_valid && !in_stall;
  assign count_next = count + 61'd1;
  assign bit_len    = {count, 3'b000};
  assign len_blk    = pass2 || (pos < LEN_POS);
  assign r1         = rc[5:0] - 6'd1;
  assign r2         = rc[5:0] - 6'd2;

  always_comb begin
    acc_merged = acc;
    acc_merged[{pos[1:0], 3'b000} +: 8] = data_byte;
  end

  always_comb begin
    head_word = '0;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < pos[1:0]) begin
        head_word[j*8 +: 8] = acc[j*8 +: 8];
      end else if (2'(j) == pos[1:0]) begin
        head_word[j*8 +: 8] = PAD_BYTE;
      end
    end
  end

  always_comb begin
    if (!pass2 && pad_w == pos[5:2]) begin
      pad_word = head_word;
    end else if (len_blk && pad_w == 4'd14) begin
      pad_word = bit_len[31:0];
    end else if (len_blk && pad_w == 4'd15) begin
      pad_word = bit_len[63:32];
    end else begin
      pad_word = '0;
    end
  end

  assign t_sum  = a + round_f(r2[5:4], b, c, d) + mk;
  assign b_next = b + rotl32(t_sum, SHIFT_AMT[{r2[5:4], r2[1:0]}]);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (byte_valid && pos == LAST_POS) begin
            state_next = S_RUN;
          end else if (is_last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pad_w == 4'd15) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (rc == RUN_END) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        if (final_blk) begin
          state_next = S_OUT;
        end else if (pad_due) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall && out_idx == LAST_INDEX) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos[5:2];
    mem_wdata = acc_merged;
    mem_raddr = msg_index(rc[5:0]);
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        mem_we   = in_fire && byte_valid && pos[1:0] == 2'd3;
      end
      S_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = pad_w;
        mem_wdata = pad_word;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = out_idx == LAST_INDEX;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= blk_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chain     <= CHAIN_IV;
      pass2     <= 1'b0;
      pad_due   <= 1'b0;
      final_blk <= 1'b0;
      pad_w     <= '0;
      rc        <= '0;
      out_idx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (byte_valid) begin
              count <= count_next;
              pad_w <= count_next[5:2];
            end else begin
              pad_w <= pos[5:2];
            end
            pad_due   <= is_last;
            final_blk <= 1'b0;
            pass2     <= 1'b0;
            rc        <= '0;
          end
        end
        S_PAD: begin
          pad_w <= pad_w + 4'd1;
          if (pad_w == 4'd15) begin
            final_blk <= len_blk;
            pad_due   <= !len_blk;
            pass2     <= !len_blk;
            rc        <= '0;
          end
        end
        S_RUN: begin
          rc <= rc + 7'd1;
        end
        S_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          pad_w    <= '0;
          out_idx  <= '0;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == LAST_INDEX) begin
              chain <= CHAIN_IV;
              count <= '0;
              pass2 <= 1'b0;
            end
          end
        end
        default: begin
          rc <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire && byte_valid) begin
      acc <= acc_merged;
    end
    if (state == S_RUN) begin
      if (rc == 7'd0) begin
        a <= chain[0];
        b <= chain[1];
        c <= chain[2];
        d <= chain[3];
      end else if (rc >= 7'd2) begin
        a <= d;
        d <= c;
        c <= b;
        b <= b_next;
      end
      if (rc >= 7'd1 && rc <= 7'd64) begin
        mk <= rdata + ROUND_K[r1];
      end
    end
  end

endmodule

// ----- rtl/core/md5sh_checker.sv -----
module md5sh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        is_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last_word
);
  import md5sh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest beat changed while stalled");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && word_index == 2'($past(word_index) + 2'd1))
    else $error("digest words out of order");

  a_digest_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !out_valid)
    else $error("digest continues after last word");

  a_no_intake_on_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while digest pending");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> in_stall)
    else $error("input not held off after last beat");

endmodule

bind md5_stream_hasher_core md5sh_checker u_md5sh_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .is_last     (is_last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);

// ----- tb/md5_stream_hasher_core_tb.sv -----
`timescale 1ns / 100ps

module md5_stream_hasher_core_tb;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam logic [1:0] FINAL_WORD = 2'd3;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int unsigned LEN_OFFSET = 56;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam logic [31:0] INIT_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int unsigned ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam int unsigned BOUNDARY_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

  typedef struct packed {
    logic [31:0] dword;
    logic [1:0]  widx;
    logic        is_final;
  } digest_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  logic [31:0] chain_q [4] = INIT_CHAIN;
  logic [31:0] blk_q [16];
  logic [60:0] byte_count = '0;

  digest_beat_t pending_digest_words [$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int message_beats = 0;
  int digests_queued = 0;
  int digests_seen = 0;
  int error_count = 0;

  md5_stream_hasher_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int unsigned r, g, ph;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (r = 0; r < 64; r++) begin
      ph = r / 16;
      case (ph)
        0: begin
          f = d ^ (b & (c ^ d));
          g = r;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = 5 * r + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * r + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * r;
        end
      endcase
      t = a + f + blk_q[g % 16] + SINE_K[r];
      t = rol32(t, ROT_AMT[ph * 4 + r % 4]) + b;
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
  endfunction

  function automatic void md5_put_byte(input int unsigned pos, input logic [7:0] v);
    blk_q[pos / 4][8 * (pos % 4) +: 8] = v;
  endfunction

  function automatic void md5_absorb_beat(input logic [7:0] b, input logic bv,
                                          input logic lst);
    int unsigned pos, k;
    logic [63:0] bit_len;
    digest_beat_t e;
    if (bv) begin
      pos = byte_count[5:0];
      md5_put_byte(pos, b);
      byte_count = byte_count + 61'd1;
      if (pos == BLOCK_BYTES - 1) md5_compress();
    end
    if (lst) begin
      pos = byte_count[5:0];
      md5_put_byte(pos, PAD_MARK);
      for (k = pos + 1; k < BLOCK_BYTES; k++) md5_put_byte(k, 8'h00);
      if (pos >= LEN_OFFSET) begin
        md5_compress();
        for (k = 0; k < 16; k++) blk_q[k] = '0;
      end
      bit_len = {byte_count, 3'b000};
      blk_q[14] = bit_len[31:0];
      blk_q[15] = bit_len[63:32];
      md5_compress();
      for (k = 0; k < 4; k++) begin
        e.dword = chain_q[k];
        e.widx = 2'(k);
        e.is_final = (2'(k) == FINAL_WORD);
        pending_digest_words.push_back(e);
      end
      chain_q = INIT_CHAIN;
      byte_count = '0;
      digests_queued++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // hold off on request, else stall at random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_digest
    digest_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_digest_words.size() == 0) begin
        report_mismatch($sformatf("digest beat %h idx %0d with none expected",
                                  digest_word, word_index));
      end else begin
        want = pending_digest_words.pop_front();
        if (digest_word !== want.dword)
          report_mismatch($sformatf("digest_word %h, want %h", digest_word, want.dword));
        if (word_index !== want.widx)
          report_mismatch($sformatf("word_index %0d, want %0d", word_index, want.widx));
        if (last_word !== want.is_final)
          report_mismatch($sformatf("last_word %b, want %b", last_word, want.is_final));
        if (want.is_final) digests_seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      byte_valid <= 1'($urandom);
      is_last <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_valid <= bv;
    is_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    md5_absorb_beat(b, bv, lst);
    if (bv || lst) message_beats++;
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    go_quiet();
    while (pending_digest_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned n_bytes, input int unsigned noise_pct);
    int unsigned k;
    logic end_on_byte;
    end_on_byte = (n_bytes > 0) && 1'($urandom);
    for (k = 0; k < n_bytes; k++) begin
      while ($urandom_range(99) < noise_pct) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, end_on_byte && (k == n_bytes - 1));
    end
    if (!end_on_byte) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    if ($urandom_range(99) < 25) return BOUNDARY_LENGTHS[$urandom_range(7)];
    return $urandom_range(20);
  endfunction

  task automatic test_empty_message();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_beat(8'hA5, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_short_messages();
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h7F, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_random_messages(input int s_pct, input int r_pct,
                                      input int min_beats, input int min_digests);
    int first_beat, first_digest;
    sender_idle_pct = s_pct;
    stall_pct = r_pct;
    first_beat = message_beats;
    first_digest = digests_queued;
    while (message_beats - first_beat < min_beats
           || digests_queued - first_digest < min_digests)
      send_message(pick_length(), 8);
  endtask

  // hold the output while the sender keeps offering beats
  task automatic test_output_holdoff();
    sender_idle_pct = 0;
    stall_pct = 0;
    go_quiet();
    @(posedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    @(negedge clk);
    send_message(40, 0);
    send_message(12, 0);
    send_message(3, 0);
  endtask

  task automatic test_drain_pause();
    sender_idle_pct = 17;
    stall_pct = 17;
    send_message(pick_length(), 8);
    wait_drained();
    send_message(pick_length(), 8);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_message();
    test_short_messages();
    test_random_messages(0, 0, 20, 1);
    test_random_messages(80, 0, 15, 1);
    test_random_messages(0, 80, 15, 1);
    test_random_messages(17, 17, 15, 1);
    test_output_holdoff();
    test_drain_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("hashed %0d byte/end beats into %0d digests, %0d digests checked",
             message_beats, digests_queued, digests_seen);
    $display({"phases: empty/short messages, block-boundary lengths, idle and stall mixes,",
              " output hold-off, drain pause"});
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- md5_stream_hasher_core.f -----
rtl/core/md5sh_pkg.sv
rtl/core/md5_stream_hasher_core.sv
rtl/core/md5sh_checker.sv
tb/md5_stream_hasher_core_tb.sv
